>>> sv/bracket_balance_checker_unit_macros.svh
// Assertion helpers for the bracket balance checker.
`ifndef BRACKET_BALANCE_CHECKER_UNIT_MACROS_SVH
`define BRACKET_BALANCE_CHECKER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BBC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define BBC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/bbc_pkg.sv
package bbc_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int LVL_W = ($clog2(STACK_DEPTH + 1) < 2) ? 2 : $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] CH_OPEN_PAREN  = 8'h28;
	localparam logic [7:0] CH_CLOSE_PAREN = 8'h29;
	localparam logic [7:0] CH_OPEN_SQ     = 8'h5B;
	localparam logic [7:0] CH_CLOSE_SQ    = 8'h5D;
	localparam logic [7:0] CH_OPEN_CURLY  = 8'h7B;
	localparam logic [7:0] CH_CLOSE_CURLY = 8'h7D;
	localparam logic [7:0] CH_OPEN_ANGLE  = 8'h3C;
	localparam logic [7:0] CH_CLOSE_ANGLE = 8'h3E;

	typedef logic [1:0] br_type_t;

	localparam br_type_t BR_PAREN = 2'd0;
	localparam br_type_t BR_SQ    = 2'd1;
	localparam br_type_t BR_CURLY = 2'd2;
	localparam br_type_t BR_ANGLE = 2'd3;

	typedef enum logic [1:0] {
		OP_NONE  = 2'd0,
		OP_OPEN  = 2'd1,
		OP_CLOSE = 2'd2
	} op_kind_t;

	typedef struct packed {
		op_kind_t kind;
		br_type_t btype;
		logic     last;
	} cmd_t;

endpackage

>>> sv/bbc_front.sv
module bbc_front (
	input  logic        char_valid,
	output logic        char_ready,
	input  logic [7:0]  char_code,
	input  logic        last_char,
	output logic        cmd_valid,
	input  logic        cmd_ready,
	output bbc_pkg::cmd_t cmd
);

	always_comb begin
		cmd.last  = last_char;
		cmd.kind  = bbc_pkg::OP_NONE;
		cmd.btype = bbc_pkg::BR_PAREN;
		case (char_code)
			bbc_pkg::CH_OPEN_PAREN: begin
				cmd.kind  = bbc_pkg::OP_OPEN;
				cmd.btype = bbc_pkg::BR_PAREN;
			end
			bbc_pkg::CH_OPEN_SQ: begin
				cmd.kind  = bbc_pkg::OP_OPEN;
				cmd.btype = bbc_pkg::BR_SQ;
			end
			bbc_pkg::CH_OPEN_CURLY: begin
				cmd.kind  = bbc_pkg::OP_OPEN;
				cmd.btype = bbc_pkg::BR_CURLY;
			end
			bbc_pkg::CH_OPEN_ANGLE: begin
				cmd.kind  = bbc_pkg::OP_OPEN;
				cmd.btype = bbc_pkg::BR_ANGLE;
			end
			bbc_pkg::CH_CLOSE_PAREN: begin
				cmd.kind  = bbc_pkg::OP_CLOSE;
				cmd.btype = bbc_pkg::BR_PAREN;
			end
			bbc_pkg::CH_CLOSE_SQ: begin
				cmd.kind  = bbc_pkg::OP_CLOSE;
				cmd.btype = bbc_pkg::BR_SQ;
			end
			bbc_pkg::CH_CLOSE_CURLY: begin
				cmd.kind  = bbc_pkg::OP_CLOSE;
				cmd.btype = bbc_pkg::BR_CURLY;
			end
			bbc_pkg::CH_CLOSE_ANGLE: begin
				cmd.kind  = bbc_pkg::OP_CLOSE;
				cmd.btype = bbc_pkg::BR_ANGLE;
			end
			default: begin
				cmd.kind  = bbc_pkg::OP_NONE;
				cmd.btype = bbc_pkg::BR_PAREN;
			end
		endcase
	end

	assign cmd_valid  = char_valid;
	assign char_ready = cmd_ready;

endmodule

>>> sv/bbc_queue.sv
module bbc_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_valid,
	output logic          wr_ready,
	input  bbc_pkg::cmd_t wr_cmd,
	output logic          rd_valid,
	input  logic          rd_ready,
	output bbc_pkg::cmd_t rd_cmd
);

	bbc_pkg::cmd_t                entry_q [bbc_pkg::QUEUE_DEPTH];
	logic [bbc_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [bbc_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [bbc_pkg::QCNT_W-1:0]   count_q;
	logic                         push;
	logic                         pop;

	assign wr_ready = (count_q != bbc_pkg::QCNT_W'(bbc_pkg::QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_cmd   = entry_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == bbc_pkg::QPTR_W'(bbc_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + bbc_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == bbc_pkg::QPTR_W'(bbc_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + bbc_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + bbc_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - bbc_pkg::QCNT_W'(1);
			end
		end
	end

endmodule

>>> sv/bbc_back.sv
module bbc_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  bbc_pkg::cmd_t cmd,
	output logic          result_valid,
	input  logic          result_ready,
	output logic          balanced,
	output logic          mismatch_seen,
	output logic          overflow_seen
);

	logic [1:0]                 stack_mem [bbc_pkg::STACK_DEPTH];
	logic [1:0]                 rd_q;
	logic [1:0]                 top_q;
	logic [bbc_pkg::LVL_W-1:0]  level_q;
	logic                       mis_q;
	logic                       ovf_q;
	logic                       res_valid_q;
	logic                       balanced_q;
	logic                       mismatch_q;
	logic                       overflow_q;

	logic                       fire;
	logic                       full;
	logic                       match;
	logic                       do_push;
	logic                       do_pop;
	logic                       mis_after;
	logic                       ovf_after;
	logic [bbc_pkg::LVL_W-1:0]  lvl_after;
	logic [bbc_pkg::LVL_W-1:0]  level_next;
	logic [bbc_pkg::LVL_W-1:0]  rd_lvl;
	logic [bbc_pkg::ADDR_W-1:0] rd_addr;
	logic [1:0]                 top_next;

	assign cmd_ready = !cmd.last || !res_valid_q || result_ready;
	assign fire      = cmd_valid && cmd_ready;
	assign full      = (level_q == bbc_pkg::LVL_W'(bbc_pkg::STACK_DEPTH));
	assign match     = (level_q != '0) && (top_q == cmd.btype);
	assign do_push   = fire && (cmd.kind == bbc_pkg::OP_OPEN) && !full;
	assign do_pop    = fire && (cmd.kind == bbc_pkg::OP_CLOSE) && match;
	assign mis_after = mis_q || (fire && (cmd.kind == bbc_pkg::OP_CLOSE) && !match);
	assign ovf_after = ovf_q || (fire && (cmd.kind == bbc_pkg::OP_OPEN) && full);

	always_comb begin
		if (do_push) begin
			lvl_after = level_q + bbc_pkg::LVL_W'(1);
			top_next  = cmd.btype;
		end else if (do_pop) begin
			lvl_after = level_q - bbc_pkg::LVL_W'(1);
			top_next  = rd_q;
		end else begin
			lvl_after = level_q;
			top_next  = top_q;
		end
		level_next = (fire && cmd.last) ? '0 : lvl_after;
		// rd_q always holds the entry just below the top for the coming cycle
		rd_lvl  = (level_next >= bbc_pkg::LVL_W'(2)) ? level_next - bbc_pkg::LVL_W'(2) : '0;
		rd_addr = rd_lvl[bbc_pkg::ADDR_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			stack_mem[level_q[bbc_pkg::ADDR_W-1:0]] <= cmd.btype;
		end
		rd_q  <= stack_mem[rd_addr];
		top_q <= top_next;
		if (fire && cmd.last) begin
			balanced_q <= (lvl_after == '0) && !mis_after && !ovf_after;
			mismatch_q <= mis_after;
			overflow_q <= ovf_after;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q     <= '0;
			mis_q       <= 1'b0;
			ovf_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			level_q <= level_next;
			mis_q   <= (fire && cmd.last) ? 1'b0 : mis_after;
			ovf_q   <= (fire && cmd.last) ? 1'b0 : ovf_after;
			if (fire && cmd.last) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid  = res_valid_q;
	assign balanced      = balanced_q;
	assign mismatch_seen = mismatch_q;
	assign overflow_seen = overflow_q;

endmodule

>>> sv/bracket_balance_checker_unit.sv
// Bracket balance checker: takes one character per cycle and, on the character flagged
// as last, returns one result telling whether ( [ { < and ) ] } > were balanced, plus
// the sticky mismatch and overflow flags. Sustained rate is one item per clock while no
// result waits; the last character passes through a queue entry, then its result is
// registered at the output. The classifier feeds a two-entry queue; the stack executor
// pops one item per cycle unless stalled, with the top entry in a register and the rest
// in a 64 x 2 memory whose registered read port always prefetches the entry below the
// top, so pushes and pops run back to back. Input stalls only while a finished result
// is not taken and the queue has filled. No clearing pass after reset; the block is ready right away.
`include "bracket_balance_checker_unit_macros.svh"

module bracket_balance_checker_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       char_valid,
	output logic       char_ready,
	input  logic [7:0] char_code,
	input  logic       last_char,
	output logic       result_valid,
	input  logic       result_ready,
	output logic       balanced,
	output logic       mismatch_seen,
	output logic       overflow_seen
);

	bbc_pkg::cmd_t front_cmd;
	bbc_pkg::cmd_t cmd;
	logic          front_valid;
	logic          front_ready;
	logic          cmd_valid;
	logic          cmd_ready;

	bbc_front u_front (
		.char_valid (char_valid),
		.char_ready (char_ready),
		.char_code  (char_code),
		.last_char  (last_char),
		.cmd_valid  (front_valid),
		.cmd_ready  (front_ready),
		.cmd        (front_cmd)
	);

	bbc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (front_valid),
		.wr_ready (front_ready),
		.wr_cmd   (front_cmd),
		.rd_valid (cmd_valid),
		.rd_ready (cmd_ready),
		.rd_cmd   (cmd)
	);

	bbc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (cmd_valid),
		.cmd_ready     (cmd_ready),
		.cmd           (cmd),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.balanced      (balanced),
		.mismatch_seen (mismatch_seen),
		.overflow_seen (overflow_seen)
	);

	`BBC_ASSERT_NOW(a_res_from_last, $rose(result_valid), $past(cmd_valid && cmd_ready && cmd.last), "result without last item")
	`BBC_ASSERT_NEXT(a_queue_fill, char_valid && char_ready && !cmd_valid, cmd_valid, "accepted item lost in queue")
	`BBC_ASSERT_NOW(a_back_stall, cmd_valid && !cmd_ready, cmd.last && result_valid && !result_ready, "executor stalled without pending result")

endmodule

>>> tb/sv/bracket_balance_checker_unit_tb.sv
`timescale 1ns / 100ps

module bracket_balance_checker_unit_tb;

	typedef struct packed {
		logic balanced;
		logic mismatch;
		logic overflow;
	} verdict_t;

	localparam verdict_t V_OK   = 3'b100;
	localparam verdict_t V_OPEN = 3'b000;
	localparam verdict_t V_MISM = 3'b010;

	typedef struct packed {
		logic [7:0] code;
		logic       last;
		logic       typed;
		verdict_t   v;
	} dir_row_t;

	localparam int N_DIR = 24;

	// typed rows carry the verdict read straight off the expression
	dir_row_t dir_rows [N_DIR] = '{
		'{bbc_pkg::CH_OPEN_PAREN,  1'b0, 1'b0, V_OPEN},
		'{bbc_pkg::CH_CLOSE_PAREN, 1'b1, 1'b1, V_OK},
		'{bbc_pkg::CH_CLOSE_PAREN, 1'b1, 1'b1, V_MISM},
		'{bbc_pkg::CH_OPEN_SQ,     1'b0, 1'b0, V_OPEN},
		'{bbc_pkg::CH_CLOSE_PAREN, 1'b0, 1'b0, V_OPEN},
		'{bbc_pkg::CH_CLOSE_SQ,    1'b1, 1'b1, V_MISM},
		'{bbc_pkg::CH_OPEN_CURLY,  1'b0, 1'b0, V_OPEN},
		'{bbc_pkg::CH_OPEN_ANGLE,  1'b0, 1'b0, V_OPEN},
		'{bbc_pkg::CH_CLOSE_ANGLE, 1'b0, 1'b0, V_OPEN},
		'{bbc_pkg::CH_CLOSE_CURLY, 1'b1, 1'b1, V_OK},
		'{8'h00,                   1'b0, 1'b0, V_OPEN},
		'{8'hFF,                   1'b1, 1'b1, V_OK},
		'{bbc_pkg::CH_OPEN_ANGLE,  1'b1, 1'b1, V_OPEN},
		'{bbc_pkg::CH_OPEN_PAREN,  1'b0, 1'b0, V_OPEN},
		'{8'h80,                   1'b0, 1'b0, V_OPEN},
		'{bbc_pkg::CH_CLOSE_ANGLE, 1'b0, 1'b0, V_OPEN},
		'{bbc_pkg::CH_CLOSE_PAREN, 1'b0, 1'b0, V_OPEN},
		'{bbc_pkg::CH_CLOSE_SQ,    1'b1, 1'b1, V_MISM},
		'{bbc_pkg::CH_OPEN_SQ,     1'b0, 1'b0, V_OPEN},
		'{bbc_pkg::CH_OPEN_CURLY,  1'b0, 1'b0, V_OPEN},
		'{bbc_pkg::CH_CLOSE_CURLY, 1'b0, 1'b0, V_OPEN},
		'{8'h7F,                   1'b0, 1'b0, V_OPEN},
		'{bbc_pkg::CH_CLOSE_SQ,    1'b1, 1'b0, V_OPEN},
		'{8'h55,                   1'b1, 1'b0, V_OPEN}
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       char_valid = 1'b0;
	logic       char_ready;
	logic [7:0] char_code = 8'h00;
	logic       last_char = 1'b0;
	logic       result_valid;
	logic       result_ready = 1'b0;
	logic       balanced;
	logic       mismatch_seen;
	logic       overflow_seen;

	bracket_balance_checker_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_valid   (char_valid),
		.char_ready   (char_ready),
		.char_code    (char_code),
		.last_char    (last_char),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.balanced     (balanced),
		.mismatch_seen(mismatch_seen),
		.overflow_seen(overflow_seen)
	);

	// predictor state
	bbc_pkg::br_type_t nest_types [bbc_pkg::STACK_DEPTH];
	int       nest_level = 0;
	bit       saw_mismatch = 0;
	bit       saw_overflow = 0;

	verdict_t expected_verdicts [$];
	int       fail_count = 0;
	int       item_count = 0;
	int       bracket_items = 0;
	int       expr_count = 0;
	int       n_balanced = 0;
	int       n_mismatch = 0;
	int       n_overflow = 0;
	bit       quiet_tail = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("simulation failed");
		$finish;
	end

	function automatic void classify(input logic [7:0] code, output bbc_pkg::op_kind_t kind,
			output bbc_pkg::br_type_t bt);
		kind = bbc_pkg::OP_NONE;
		bt = bbc_pkg::BR_PAREN;
		case (code)
			bbc_pkg::CH_OPEN_PAREN:  begin kind = bbc_pkg::OP_OPEN;  bt = bbc_pkg::BR_PAREN; end
			bbc_pkg::CH_OPEN_SQ:     begin kind = bbc_pkg::OP_OPEN;  bt = bbc_pkg::BR_SQ;    end
			bbc_pkg::CH_OPEN_CURLY:  begin kind = bbc_pkg::OP_OPEN;  bt = bbc_pkg::BR_CURLY; end
			bbc_pkg::CH_OPEN_ANGLE:  begin kind = bbc_pkg::OP_OPEN;  bt = bbc_pkg::BR_ANGLE; end
			bbc_pkg::CH_CLOSE_PAREN: begin kind = bbc_pkg::OP_CLOSE; bt = bbc_pkg::BR_PAREN; end
			bbc_pkg::CH_CLOSE_SQ:    begin kind = bbc_pkg::OP_CLOSE; bt = bbc_pkg::BR_SQ;    end
			bbc_pkg::CH_CLOSE_CURLY: begin kind = bbc_pkg::OP_CLOSE; bt = bbc_pkg::BR_CURLY; end
			bbc_pkg::CH_CLOSE_ANGLE: begin kind = bbc_pkg::OP_CLOSE; bt = bbc_pkg::BR_ANGLE; end
			default: ;
		endcase
	endfunction

	function automatic logic [7:0] opener_of(input bbc_pkg::br_type_t bt);
		case (bt)
			bbc_pkg::BR_PAREN: return bbc_pkg::CH_OPEN_PAREN;
			bbc_pkg::BR_SQ:    return bbc_pkg::CH_OPEN_SQ;
			bbc_pkg::BR_CURLY: return bbc_pkg::CH_OPEN_CURLY;
			default:           return bbc_pkg::CH_OPEN_ANGLE;
		endcase
	endfunction

	function automatic logic [7:0] closer_of(input bbc_pkg::br_type_t bt);
		case (bt)
			bbc_pkg::BR_PAREN: return bbc_pkg::CH_CLOSE_PAREN;
			bbc_pkg::BR_SQ:    return bbc_pkg::CH_CLOSE_SQ;
			bbc_pkg::BR_CURLY: return bbc_pkg::CH_CLOSE_CURLY;
			default:           return bbc_pkg::CH_CLOSE_ANGLE;
		endcase
	endfunction

	// advances the nesting state by one character; returns 1 with the verdict on the last one
	function automatic bit predict_char(input logic [7:0] code, input logic last,
			output verdict_t v);
		bbc_pkg::op_kind_t kind;
		bbc_pkg::br_type_t bt;
		classify(code, kind, bt);
		v = V_OPEN;
		if (kind == bbc_pkg::OP_OPEN) begin
			if (nest_level < bbc_pkg::STACK_DEPTH) begin
				nest_types[nest_level] = bt;
				nest_level++;
			end else
				saw_overflow = 1;
		end else if (kind == bbc_pkg::OP_CLOSE) begin
			if (nest_level > 0 && nest_types[nest_level - 1] == bt)
				nest_level--;
			else
				saw_mismatch = 1;
		end
		if (!last)
			return 0;
		v.balanced = (nest_level == 0) && !saw_mismatch && !saw_overflow;
		v.mismatch = saw_mismatch;
		v.overflow = saw_overflow;
		nest_level = 0;
		saw_mismatch = 0;
		saw_overflow = 0;
		return 1;
	endfunction

	task automatic send_char(input logic [7:0] code, input logic last, input logic typed,
			input verdict_t tv);
		verdict_t v;
		bbc_pkg::op_kind_t kind;
		bbc_pkg::br_type_t bt;
		char_valid <= 1'b1;
		char_code <= code;
		last_char <= last;
		do @(posedge clk); while (!char_ready);
		item_count++;
		classify(code, kind, bt);
		if (kind != bbc_pkg::OP_NONE || last)
			bracket_items++;
		if (predict_char(code, last, v)) begin
			if (typed)
				v = tv;
			expected_verdicts.push_back(v);
			expr_count++;
			n_balanced += v.balanced;
			n_mismatch += v.mismatch;
			n_overflow += v.overflow;
		end
		if (!quiet_tail && $urandom_range(0, 5) == 0) begin
			char_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	task automatic send_expr(input logic [7:0] chars [$]);
		for (int i = 0; i < chars.size(); i++)
			send_char(chars[i], i == chars.size() - 1, 1'b0, V_OPEN);
	endtask

	task automatic build_nested(output logic [7:0] chars [$], input int maxd, input int len);
		bbc_pkg::br_type_t open_q [$];
		bbc_pkg::br_type_t bt;
		int r;
		chars = {};
		repeat (len) begin
			r = $urandom_range(0, 9);
			if (r < 4 && open_q.size() < maxd) begin
				bt = bbc_pkg::br_type_t'($urandom_range(0, 3));
				open_q.push_back(bt);
				chars.push_back(opener_of(bt));
			end else if (r < 8 && open_q.size() > 0)
				chars.push_back(closer_of(open_q.pop_back()));
			else
				chars.push_back(8'($urandom_range(0, 255)));
		end
		while (open_q.size() > 0)
			chars.push_back(closer_of(open_q.pop_back()));
		if (chars.size() == 0)
			chars.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic build_deep(output logic [7:0] chars [$], input int depth);
		bbc_pkg::br_type_t types [$];
		bbc_pkg::br_type_t bt;
		chars = {};
		for (int i = 0; i < depth; i++) begin
			bt = bbc_pkg::br_type_t'($urandom_range(0, 3));
			types.push_back(bt);
			chars.push_back(opener_of(bt));
		end
		for (int i = ((depth < bbc_pkg::STACK_DEPTH) ? depth : bbc_pkg::STACK_DEPTH) - 1;
				i >= 0; i--)
			chars.push_back(closer_of(types[i]));
	endtask

	function automatic logic [7:0] any_bracket();
		bbc_pkg::br_type_t bt;
		bt = bbc_pkg::br_type_t'($urandom_range(0, 3));
		return $urandom_range(0, 1) ? opener_of(bt) : closer_of(bt);
	endfunction

	task automatic report_field(input string fname, input logic exp_v, input logic act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s wrong, expected %0b, got %0b", $time, fname, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		verdict_t ev;
		if (arst_n && result_valid && result_ready) begin
			if (expected_verdicts.size() == 0) begin
				$display("%0t: unexpected result, expected none, got bal=%0b mm=%0b ov=%0b",
					$time, balanced, mismatch_seen, overflow_seen);
				fail_count++;
			end else begin
				ev = expected_verdicts.pop_front();
				report_field("balanced", ev.balanced, balanced);
				report_field("mismatch_seen", ev.mismatch, mismatch_seen);
				report_field("overflow_seen", ev.overflow, overflow_seen);
			end
		end
	end

	initial begin
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!quiet_tail && $urandom_range(0, 2) == 0) begin
				result_ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
			result_ready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
	end

	initial begin
		logic [7:0] chars [$];
		bit drained;
		int mode;
		drained = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIR; i++)
			send_char(dir_rows[i].code, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].v);

		// full stack exactly, then one past it
		build_deep(chars, bbc_pkg::STACK_DEPTH);
		send_expr(chars);
		build_deep(chars, bbc_pkg::STACK_DEPTH + 1);
		send_expr(chars);

		while (item_count < 1200) begin
			mode = $urandom_range(0, 99);
			if (mode < 60)
				build_nested(chars, $urandom_range(1, 10), $urandom_range(1, 30));
			else if (mode < 80) begin
				build_nested(chars, $urandom_range(1, 10), $urandom_range(1, 30));
				repeat ($urandom_range(1, 2))
					chars[$urandom_range(0, chars.size() - 1)] = any_bracket();
			end else if (mode < 97) begin
				chars = {};
				repeat ($urandom_range(1, 15))
					chars.push_back($urandom_range(0, 1) ? any_bracket()
						: 8'($urandom_range(0, 255)));
			end else
				build_deep(chars, $urandom_range(bbc_pkg::STACK_DEPTH - 2,
					bbc_pkg::STACK_DEPTH + 4));
			send_expr(chars);

			if (!drained && item_count >= 600) begin
				drained = 1;
				char_valid <= 1'b0;
				do @(posedge clk); while (expected_verdicts.size() != 0);
			end
			if (item_count >= 1050)
				quiet_tail = 1;
		end

		char_valid <= 1'b0;
		while (expected_verdicts.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("ran %0d items (%0d bracket or final characters) over %0d expressions",
			item_count, bracket_items, expr_count);
		$display("verdicts: %0d balanced, %0d with mismatch, %0d with overflow", n_balanced,
			n_mismatch, n_overflow);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

>>> sim.f
+incdir+sv
sv/bbc_pkg.sv
sv/bbc_front.sv
sv/bbc_queue.sv
sv/bbc_back.sv
sv/bracket_balance_checker_unit.sv
tb/sv/bracket_balance_checker_unit_tb.sv
